// ----- sv/pll_pkg.sv -----
// Shared constants, widths and word layouts for the piecewise-linear lookup core.
`default_nettype none

package pll_pkg;

  localparam int MAX_POINTS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int STEP_W = $clog2(DATA_W);
  localparam int PROD_W = 2 * DATA_W;
  localparam int OFF_W  = PROD_W - FRAC_BITS + 1;
  localparam int XF_W   = OFF_W + 2;

  localparam int IN_BITS    = ADDR_W + 3 * DATA_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(2);

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] x;
  } point_t;

endpackage

`default_nettype wire

// ----- sv/piecewise_linear_lookup_core.sv -----
// Piecewise-linear lookup core: breakpoint table, segment scan, serial multiply and divide.
// A write word goes from acceptance to ST_DONE and from there into the output register.
// A query primes the scan, compares segments in turn, then runs a serial multiply and a serial divide;
// a relative query first runs a serial multiply of its own to map its position onto the table.
// One word is in work at a time; no new word is taken until the last one has left ST_DONE.
// Reset clears control state and sets point_count to two; the table is undefined until written.
`default_nettype none

module piecewise_linear_lookup_core
  import pll_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CNT_W-1:0]       cfg_wdata_i,     // point_count
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // point_index, point_x, point_y, query_pos, zero padding
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic [1:0]             s_axis_tuser_i,  // mode, relative
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,  // value_out
  output logic                        m_axis_tuser_o   // found
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REL_A,
    ST_REL_B,
    ST_REL_C,
    ST_FILL,
    ST_PRIME,
    ST_CMP,
    ST_MUL,
    ST_DIV,
    ST_Y,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    n_lim;
  logic [CNT_W-1:0]    ptr_q;
  logic [STEP_W-1:0]   step_q;
  logic [ADDR_W-1:0]   rd_addr;
  point_t              mem [MAX_POINTS];
  point_t              rdata_q;
  point_t              prev_q;
  logic [DATA_W-1:0]   qpos_q;
  logic [DATA_W-1:0]   xf_q;
  logic [DATA_W-1:0]   x_q;
  logic [DATA_W-1:0]   y0_q;
  logic [DATA_W-1:0]   dx_q;
  logic                neg_q;
  logic                rel_mul_q;
  logic [DATA_W-1:0]   hi_q;
  logic [DATA_W-1:0]   lo_q;
  logic [DATA_W-1:0]   opa_q;
  logic [DATA_W-1:0]   res_value_q;
  logic                res_found_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_value_q;
  logic                out_found_q;

  logic                s_acc;
  logic                out_free;
  logic [ADDR_W-1:0]   in_index;
  logic [DATA_W-1:0]   in_x;
  logic [DATA_W-1:0]   in_y;
  logic [DATA_W-1:0]   in_q;
  logic                in_mode;
  logic                in_rel;

  logic [DATA_W:0]     diff;
  logic [DATA_W-1:0]   diff_mag;
  logic [DATA_W-1:0]   q_mag;
  logic [PROD_W-1:0]   prod;
  logic [OFF_W-1:0]    off_mag;
  logic [XF_W-1:0]     off_s;
  logic [XF_W-1:0]     x_full;
  logic                x_in_range;
  logic                hit;
  logic [DATA_W:0]     dy;
  logic [DATA_W-1:0]   dy_mag;
  logic [DATA_W:0]     t_full;
  logic [DATA_W:0]     dx_full;
  logic [DATA_W:0]     mul_sum;
  logic [DATA_W:0]     div_rs;
  logic [DATA_W:0]     div_diff;
  logic                div_ok;
  logic [DATA_W+1:0]   y_full;
  logic [DATA_W-1:0]   y_sat;

  assign in_index = s_axis_tdata_i[ADDR_W-1:0];
  assign in_x     = s_axis_tdata_i[ADDR_W +: DATA_W];
  assign in_y     = s_axis_tdata_i[ADDR_W + DATA_W +: DATA_W];
  assign in_q     = s_axis_tdata_i[ADDR_W + 2 * DATA_W +: DATA_W];
  assign in_mode  = s_axis_tuser_i[0];
  assign in_rel   = s_axis_tuser_i[1];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_value_q);
  assign m_axis_tuser_o  = out_found_q;

  assign n_lim = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;

  always_comb begin
    unique case (state_q)
      ST_REL_A:                   rd_addr = ADDR_W'(n_lim - CNT_W'(1));
      ST_FILL, ST_PRIME, ST_CMP:  rd_addr = ptr_q[ADDR_W-1:0];
      default:                    rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && (mode_e'(in_mode) == MODE_WRITE)) begin
      mem[in_index] <= '{y: in_y, x: in_x};
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    diff     = {rdata_q.x[DATA_W-1], rdata_q.x} - {xf_q[DATA_W-1], xf_q};
    diff_mag = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    q_mag    = qpos_q[DATA_W-1] ? DATA_W'(-qpos_q) : qpos_q;

    prod     = {hi_q, lo_q};
    off_mag  = OFF_W'(prod[PROD_W-1:FRAC_BITS])
             + OFF_W'(neg_q && (prod[FRAC_BITS-1:0] != '0));
    off_s    = neg_q ? XF_W'(-{2'b00, off_mag}) : {2'b00, off_mag};
    x_full   = {{(XF_W-DATA_W){xf_q[DATA_W-1]}}, xf_q} + off_s;
    x_in_range = (&x_full[XF_W-1:DATA_W-1]) || !(|x_full[XF_W-1:DATA_W-1]);

    hit      = ($signed(prev_q.x) < $signed(rdata_q.x))
            && ($signed(prev_q.x) <= $signed(x_q))
            && ($signed(x_q) <= $signed(rdata_q.x));
    dy       = {rdata_q.y[DATA_W-1], rdata_q.y} - {prev_q.y[DATA_W-1], prev_q.y};
    dy_mag   = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
    t_full   = {x_q[DATA_W-1], x_q} - {prev_q.x[DATA_W-1], prev_q.x};
    dx_full  = {rdata_q.x[DATA_W-1], rdata_q.x} - {prev_q.x[DATA_W-1], prev_q.x};

    mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opa_q} : '0);

    div_rs   = {hi_q, lo_q[DATA_W-1]};
    div_diff = div_rs - {1'b0, opa_q};
    div_ok   = (div_rs >= {1'b0, opa_q});

    y_full   = neg_q ? ({{2{y0_q[DATA_W-1]}}, y0_q} - {2'b00, lo_q})
                     : ({{2{y0_q[DATA_W-1]}}, y0_q} + {2'b00, lo_q});
    if (y_full[DATA_W+1:DATA_W-1] == 3'b000 || y_full[DATA_W+1:DATA_W-1] == 3'b111) begin
      y_sat = y_full[DATA_W-1:0];
    end else if (y_full[DATA_W+1]) begin
      y_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= POINT_COUNT_RST;
      ptr_q       <= '0;
      step_q      <= '0;
      prev_q      <= '0;
      qpos_q      <= '0;
      xf_q        <= '0;
      x_q         <= '0;
      y0_q        <= '0;
      dx_q        <= '0;
      neg_q       <= 1'b0;
      rel_mul_q   <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
      opa_q       <= '0;
      res_value_q <= '0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end

      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        out_value_q <= res_value_q;
        out_found_q <= res_found_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            res_value_q <= '0;
            res_found_q <= 1'b0;
            qpos_q      <= in_q;
            x_q         <= in_q;
            ptr_q       <= CNT_W'(1);
            if (mode_e'(in_mode) == MODE_WRITE || n_lim < CNT_W'(2)) begin
              state_q <= ST_DONE;
            end else if (in_rel) begin
              state_q <= ST_REL_A;
            end else begin
              state_q <= ST_PRIME;
            end
          end
        end
        ST_REL_A: begin
          xf_q    <= rdata_q.x;
          state_q <= ST_REL_B;
        end
        ST_REL_B: begin
          hi_q      <= '0;
          lo_q      <= q_mag;
          opa_q     <= diff_mag;
          neg_q     <= qpos_q[DATA_W-1] ^ diff[DATA_W];
          step_q    <= '0;
          rel_mul_q <= 1'b1;
          state_q   <= ST_MUL;
        end
        ST_REL_C: begin
          x_q   <= x_full[DATA_W-1:0];
          ptr_q <= '0;
          if (x_in_range) begin
            state_q <= ST_FILL;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_FILL: begin
          ptr_q   <= CNT_W'(1);
          state_q <= ST_PRIME;
        end
        ST_PRIME: begin
          prev_q  <= rdata_q;
          ptr_q   <= ptr_q + CNT_W'(1);
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (hit) begin
            hi_q      <= '0;
            lo_q      <= t_full[DATA_W-1:0];
            opa_q     <= dy_mag;
            dx_q      <= dx_full[DATA_W-1:0];
            y0_q      <= prev_q.y;
            neg_q     <= dy[DATA_W];
            step_q    <= '0;
            rel_mul_q <= 1'b0;
            state_q   <= ST_MUL;
          end else if (ptr_q == n_lim) begin
            state_q <= ST_DONE;
          end else begin
            prev_q <= rdata_q;
            ptr_q  <= ptr_q + CNT_W'(1);
          end
        end
        ST_MUL: begin
          hi_q   <= mul_sum[DATA_W:1];
          lo_q   <= {mul_sum[0], lo_q[DATA_W-1:1]};
          step_q <= step_q + STEP_W'(1);
          if (step_q == '1) begin
            step_q <= '0;
            if (rel_mul_q) begin
              state_q <= ST_REL_C;
            end else begin
              opa_q   <= dx_q;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          hi_q   <= div_ok ? div_diff[DATA_W-1:0] : div_rs[DATA_W-1:0];
          lo_q   <= {lo_q[DATA_W-2:0], div_ok};
          step_q <= step_q + STEP_W'(1);
          if (step_q == '1) begin
            step_q  <= '0;
            state_q <= ST_Y;
          end
        end
        ST_Y: begin
          res_value_q <= y_sat;
          res_found_q <= 1'b1;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_value_q == '0)
    else $error("result without a segment carries a non-zero value");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> opa_q != '0)
    else $error("division started with a zero divisor");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> hi_q < opa_q)
    else $error("partial remainder not below divisor");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second word taken while one is in work");

endmodule

`default_nettype wire

// ----- test/piecewise_linear_lookup_core_tb.sv -----
// Self-checking testbench for the piecewise-linear lookup core, with a directed and a random part.
module piecewise_linear_lookup_core_tb;
  import pll_pkg::*;

  typedef struct packed {
    mode_e             mode;
    logic              relative;
    logic [ADDR_W-1:0] index;
    logic [DATA_W-1:0] point_x;
    logic [DATA_W-1:0] point_y;
    logic [DATA_W-1:0] query_pos;
  } lookup_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              found;
  } lookup_res_t;

  typedef struct packed {
    mode_e             mode;
    logic              relative;
    logic [ADDR_W-1:0] index;
    logic [DATA_W-1:0] point_x;
    logic [DATA_W-1:0] point_y;
    logic [DATA_W-1:0] query_pos;
    logic              typed;
    logic [DATA_W-1:0] exp_value;
    logic              exp_found;
  } dir_row_t;

  localparam int DIR_ROWS     = 22;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 95;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;

  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -longint'(2147483647) - 1;

  // Extremes first, then a zero-width and a falling-x segment, then a short falling-y ramp.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{MODE_WRITE, 1'b0, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_WRITE, 1'b0, 5'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 32'h8000_0000, 1'b1},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
    '{MODE_WRITE, 1'b0, 5'd0, 32'h0, 32'h0000_0005, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_WRITE, 1'b0, 5'd1, 32'h0, 32'h0001_0000, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_WRITE, 1'b0, 5'd1, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'hFFFF_8000, 1'b1, 32'h0, 1'b0},
    '{MODE_WRITE, 1'b0, 5'd1, 32'h0004_0000, 32'hFFFE_0000, 32'h0, 1'b1, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0003_0000, 1'b0, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b1, 5'd0, 32'h0, 32'h0, 32'h0000_4000, 1'b0, 32'h0, 1'b0},
    '{MODE_QUERY, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0000_0005, 1'b1},
    '{MODE_WRITE, 1'b1, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0}
  };

  localparam logic [CNT_W-1:0] PHASE_COUNT [PHASES] = '{0, 1, 63, 2, 32, 17, 33, 0, 3, 32};

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  wire                    in_ready;
  logic [IN_TDATA_W-1:0]  in_data   = '0;
  logic [1:0]             in_user   = '0;
  wire                    out_valid;
  logic                   out_ready = 1'b0;
  wire [OUT_TDATA_W-1:0]  out_data;
  wire                    out_user;

  logic [DATA_W-1:0] tbl_x [MAX_POINTS];
  logic [DATA_W-1:0] tbl_y [MAX_POINTS];
  bit                tbl_set [MAX_POINTS];
  logic [CNT_W-1:0]  pt_count = POINT_COUNT_RST;

  lookup_res_t pending_q [$];
  int          errors   = 0;
  bit          burst    = 1'b0;
  bit          hold_req = 1'b0;

  piecewise_linear_lookup_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic lookup_res_t lookup_predict(input lookup_word_t w);
    lookup_res_t r;
    int          n;
    int          i;
    longint      xq, xf, xl, x0, x1, y0, y1, dy, yv;
    bit [63:0]   mag, prod, quo;
    r = '0;
    if (w.mode == MODE_WRITE) begin
      tbl_x[w.index]   = w.point_x;
      tbl_y[w.index]   = w.point_y;
      tbl_set[w.index] = 1'b1;
      return r;
    end
    n = (pt_count > MAX_POINTS) ? MAX_POINTS : int'(pt_count);
    if (n < 2) return r;
    xq = longint'($signed(w.query_pos));
    if (w.relative) begin
      xf = longint'($signed(tbl_x[0]));
      xl = longint'($signed(tbl_x[n-1]));
      xq = xf + ((xq * (xl - xf)) >>> FRAC_BITS);
    end
    for (i = 0; i + 1 < n; i++) begin
      x0 = longint'($signed(tbl_x[i]));
      x1 = longint'($signed(tbl_x[i+1]));
      if (x0 < x1 && x0 <= xq && xq <= x1) begin
        y0   = longint'($signed(tbl_y[i]));
        y1   = longint'($signed(tbl_y[i+1]));
        dy   = y1 - y0;
        mag  = (dy < 0) ? 64'(-dy) : 64'(dy);
        prod = mag * 64'(xq - x0);
        quo  = prod / 64'(x1 - x0);
        yv   = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
        if (yv > SAT_HI) yv = SAT_HI;
        if (yv < SAT_LO) yv = SAT_LO;
        r.value = yv[DATA_W-1:0];
        r.found = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  function automatic lookup_word_t rand_word();
    lookup_word_t w;
    w.mode      = mode_e'($urandom_range(0, 1));
    w.relative  = 1'($urandom_range(0, 1));
    w.index     = ADDR_W'($urandom);
    w.point_x   = $urandom;
    w.point_y   = $urandom;
    w.query_pos = $urandom;
    return w;
  endfunction

  task automatic push_word(input lookup_word_t w, input bit typed, input lookup_res_t typed_res);
    int          gap;
    lookup_res_t r;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, w.query_pos, w.point_y, w.point_x, w.index};
    in_user  <= {w.relative, w.mode};
    do @(posedge clk); while (in_ready !== 1'b1);
    r = lookup_predict(w);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input bit fast, input bit hold);
    lookup_word_t w;
    lookup_res_t  none;
    int           n, sent, seg, pick, i, hole;
    longint       gmax, room, xv, lo, hi;
    none = '0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pt_count = count;
    burst    = fast;
    hold_req = hold;
    n    = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
    sent = 0;
    // Mostly a rising table over the points in use, with an odd flat or falling step.
    if (n >= 2 && $urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0: gmax = 16;
        1: gmax = 'h100;
        2: gmax = 'h1_0000;
        default: gmax = 64'hFFFF_FFFF / (n - 1);
      endcase
      room = 64'hFFFF_FFFF - (n - 1) * gmax;
      xv   = SAT_LO + longint'($urandom_range(32'(room), 0));
      for (i = 0; i < n; i++) begin
        if (i != 0) begin
          case ($urandom_range(0, 11))
            0: ;
            1: begin
              xv = xv - longint'($urandom_range(32'(gmax), 1));
              if (xv < SAT_LO) xv = SAT_LO;
            end
            default: xv = xv + longint'($urandom_range(32'(gmax), 1));
          endcase
        end
        w         = rand_word();
        w.mode    = MODE_WRITE;
        w.index   = ADDR_W'(i);
        w.point_x = xv[DATA_W-1:0];
        if ($urandom_range(0, 1) == 0) w.point_y = 32'($urandom_range(0, 'h3_0000)) - 32'h1_8000;
        push_word(w, 1'b0, none);
        sent++;
      end
    end
    while (sent < PHASE_WORDS) begin
      w      = rand_word();
      w.mode = MODE_QUERY;
      pick   = $urandom_range(0, 99);
      hole   = -1;
      for (i = 0; i < n; i++) if (!tbl_set[i] && hole < 0) hole = i;
      if (hole >= 0) begin
        w.mode  = MODE_WRITE;
        w.index = ADDR_W'(hole);
      end else if (pick < 55 && n >= 2) begin
        seg        = $urandom_range(0, n - 2);
        lo         = longint'($signed(tbl_x[seg]));
        hi         = longint'($signed(tbl_x[seg+1]));
        w.relative = 1'b0;
        if (lo >= hi) xv = lo;
        else begin
          case ($urandom_range(0, 5))
            0: xv = lo;
            1: xv = hi;
            default: xv = lo + longint'($urandom_range(32'(hi - lo), 0));
          endcase
        end
        w.query_pos = xv[DATA_W-1:0];
      end else if (pick < 75) begin
        w.relative  = 1'b1;
        w.query_pos = 32'($urandom_range(0, 'h1_2000)) - 32'h1000;
      end else if (pick >= 90) begin
        w.mode = MODE_WRITE;
      end
      push_word(w, 1'b0, none);
      sent++;
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    lookup_word_t w;
    lookup_res_t  res;
    int           k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < DIR_ROWS; k++) begin
      w.mode      = DIR_TABLE[k].mode;
      w.relative  = DIR_TABLE[k].relative;
      w.index     = DIR_TABLE[k].index;
      w.point_x   = DIR_TABLE[k].point_x;
      w.point_y   = DIR_TABLE[k].point_y;
      w.query_pos = DIR_TABLE[k].query_pos;
      res.value   = DIR_TABLE[k].exp_value;
      res.found   = DIR_TABLE[k].exp_found;
      push_word(w, DIR_TABLE[k].typed, res);
    end
    in_valid <= 1'b0;
    for (k = 0; k < PHASES; k++) begin
      if (k == 7) run_phase(CNT_W'($urandom_range(0, 63)), 1'b0, 1'b0);
      else run_phase(PHASE_COUNT[k], k == 3 || k == 4, k == 4);
    end
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("piecewise_linear_lookup_core test passed");
    end else begin
      $display("piecewise_linear_lookup_core test failed");
    end
    $finish;
  end

  // The long hold-off is counted here, so that the sender keeps offering words meanwhile.
  initial begin : result_sink
    int          stall;
    lookup_res_t e;
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: value %h found %b", out_data, out_user);
      end else begin
        e = pending_q.pop_front();
        if (out_data[DATA_W-1:0] !== e.value || out_user !== e.found) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: value expected %h got %h, found expected %b got %b",
                     e.value, out_data[DATA_W-1:0], e.found, out_user);
        end
      end
    end
  end

  initial begin : watchdog
    #6_000_000;
    $display("piecewise_linear_lookup_core test failed");
    $finish;
  end

endmodule
